/* hdl/ase_pkg.sv */
// ----------------------------------------------------------------------------
// ase_pkg
// shared types and constants of the ascending sort engine
// ----------------------------------------------------------------------------
`default_nettype none
package ase_pkg;
    localparam int MaxKeys  = 64;
    localparam int KeyW     = 64;
    localparam int AddrW    = $clog2(MaxKeys);
    localparam int CountW   = $clog2(MaxKeys + 1);

    typedef enum logic [2:0] {
        S_FILL,
        S_OUTER,
        S_READ,
        S_CMP,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    // signed compare on raw key bits
    function automatic logic key_less(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
        key_less = $signed(a) < $signed(b);
    endfunction
endpackage
`default_nettype wire

/* hdl/ase_if.sv */
// ----------------------------------------------------------------------------
// ase_in_if / ase_out_if
// valid/ready channels for keys and sorted results
// ----------------------------------------------------------------------------
`default_nettype none
interface ase_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] key;
    logic        final_key;
    modport source (output valid, key, final_key, input ready);
    modport sink   (input valid, key, final_key, output ready);
endinterface

interface ase_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] sorted_key;
    logic        run_end;
    logic        overflow;
    modport source (output valid, sorted_key, run_end, overflow, input ready);
    modport sink   (input valid, sorted_key, run_end, overflow, output ready);
endinterface
`default_nettype wire

/* hdl/ase_ram.sv */
// ----------------------------------------------------------------------------
// ase_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ase_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write or read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* hdl/ascending_sort_engine.sv */
// ----------------------------------------------------------------------------
// ascending_sort_engine
// collects keys into a store, insertion sorts them in place, streams them out
// ----------------------------------------------------------------------------
// usage:
//  - keys enter on i_in, one transaction per cycle while filling and no
//    result is pending; the transaction with final_key set closes the set
//  - keys beyond 64 are dropped and overflow is flagged on every result
//  - after the closing key the store is insertion sorted in the key ram,
//    one ram access per cycle: each compare is a read state then a write
//    state, and each outer step adds one more state that reads the item
//  - results leave on o_out, each read then emitted from the same ram port;
//    run_end marks the last; i_in is not ready until the run is delivered
//  - a stalled receiver holds the result register; the emit sequence waits
//  - reset (i_rst_n low, synchronous) empties the store; ram contents are
//    not cleared since only written entries are read
// ----------------------------------------------------------------------------
`default_nettype none
module ascending_sort_engine (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ase_in_if.sink   i_in,
    ase_out_if.source o_out
);
    import ase_pkg::*;

    t_state            r_state, n_state;
    logic [CountW-1:0] r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [CountW-1:0] r_i, n_i;     // outer index
    logic [AddrW-1:0]  r_pos, n_pos; // hole position
    logic [KeyW-1:0]   r_item, n_item;
    logic              r_ovalid, n_ovalid;
    logic [KeyW-1:0]   r_okey, n_okey;
    logic              r_oend, n_oend;

    logic              ram_we;
    logic [AddrW-1:0]  ram_addr;
    logic [KeyW-1:0]   ram_wdata, ram_rdata;

    ase_ram #(.Width(KeyW), .Depth(MaxKeys)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic in_fire, out_fire;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_ovalid && o_out.ready;

    assign i_in.ready       = (r_state == S_FILL) && !r_ovalid;
    assign o_out.valid      = r_ovalid;
    assign o_out.sorted_key = r_okey;
    assign o_out.run_end    = r_oend;
    assign o_out.overflow   = r_ovf;

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_i      = r_i;
        n_pos    = r_pos;
        n_item   = r_item;
        n_ovalid = r_ovalid && !o_out.ready;
        n_okey   = r_okey;
        n_oend   = r_oend;
        unique case (r_state)
            S_FILL: begin
                if (in_fire) begin
                    if (r_count < CountW'(MaxKeys)) n_count = r_count + 1'b1;
                    else n_ovf = 1'b1;
                    if (i_in.final_key) begin
                        n_i = CountW'(1);
                        n_state = S_OUTER;
                    end
                end
            end
            S_OUTER: begin
                if (r_i >= r_count) begin
                    n_i = '0;
                    n_state = (r_count == '0) ? S_FILL : S_EMIT_RD;
                    if (r_count == '0) n_ovf = 1'b0;
                end else begin
                    n_pos = r_i[AddrW-1:0];
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // item read arrives on ram_rdata when pos equals i
                if (r_pos == r_i[AddrW-1:0]) n_item = ram_rdata;
                if (r_pos == '0) n_state = S_CMP;
                else n_state = S_CMP;
            end
            S_CMP: begin
                // ram_rdata holds store[pos-1] here
                n_state = S_READ;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_okey   = ram_rdata;
                    n_oend   = (r_i + 1'b1 == r_count);
                    if (r_i + 1'b1 == r_count) begin
                        n_count = '0;
                        n_state = S_FILL;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_FILL;
        endcase
        if (r_state == S_FILL && r_ovalid && out_fire && r_oend) n_ovf = 1'b0;
    end

    // sort sub-sequencer flag: r_sub is only ever cleared (in READ), so it stays low
    logic r_sub, n_sub;
    logic prev_less;
    assign prev_less = key_less(r_item, ram_rdata);

    // ram port use
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_pos;
        ram_wdata = r_item;
        n_sub     = r_sub;
        unique case (r_state)
            S_FILL: begin
                ram_addr  = r_count[AddrW-1:0];
                ram_wdata = i_in.key;
                ram_we    = in_fire && (r_count < CountW'(MaxKeys));
            end
            S_OUTER: ram_addr = r_i[AddrW-1:0];
            S_READ: begin
                ram_addr = r_pos - 1'b1;
                n_sub = 1'b0;
            end
            S_CMP: begin
                ram_addr = r_pos;
                ram_wdata = (r_pos != '0 && prev_less) ? ram_rdata : r_item;
                ram_we = 1'b1;
            end
            S_EMIT_RD: ram_addr = r_i[AddrW-1:0];
            S_EMIT: ram_addr = r_i[AddrW-1:0];
            default: ram_addr = r_pos;
        endcase
    end

    // capture item in READ; in CMP compare it against store[pos-1], shift that up or finish
    t_state sort_state;
    logic [AddrW-1:0] sort_pos;
    logic [CountW-1:0] sort_i;
    logic [KeyW-1:0] sort_item;
    always_comb begin
        sort_state = n_state;
        sort_pos   = n_pos;
        sort_i     = n_i;
        sort_item  = n_item;
        if (r_state == S_READ) begin
            sort_item = (r_pos == r_i[AddrW-1:0]) ? ram_rdata : r_item;
        end
        if (r_state == S_CMP) begin
            if (r_pos != '0 && prev_less) begin
                sort_pos = r_pos - 1'b1;
                sort_state = S_READ;
            end else begin
                sort_i = r_i + 1'b1;
                sort_state = S_OUTER;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_sub    <= 1'b0;
        end else begin
            r_state  <= sort_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
            r_i      <= sort_i;
            r_sub    <= n_sub;
        end
        r_pos  <= sort_pos;
        r_item <= sort_item;
        r_okey <= n_okey;
        r_oend <= n_oend;
    end

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(MaxKeys)) else $error("key count beyond store");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_state == S_FILL)) else $error("key taken while sorting");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_ovalid && n_oend && !r_sub) |=> (r_count == '0))
        else $error("count not cleared after run");
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives key sets into the ascending sort engine, predicts each sorted run
// and compares every result transaction field by field
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import ase_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KeyW-1:0] sorted_key;
        logic            run_end;
        logic            overflow;
    } t_sorted;

    logic i_clk;
    logic i_rst_n;
    ase_in_if  in_if ();
    ase_out_if out_if ();

    ascending_sort_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // predictor state: keys of the open set
    logic [KeyW-1:0] held_keys[$];
    bit              keys_dropped;
    t_sorted         sorted_q[$];
    int              fail_count;
    int              results_seen;
    int              sets_sent;
    int              burst_left;
    int              stall_mode;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall limit: generous margin for the worst-case sorts
    initial begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

    // insertion sort of the open set, queue expected run
    function automatic void predict_run();
        logic [KeyW-1:0] keys[$];
        logic [KeyW-1:0] tmp;
        int j;
        t_sorted r;
        keys = held_keys;
        for (int i = 1; i < keys.size(); i++) begin
            tmp = keys[i];
            j = i;
            while (j > 0 && $signed(tmp) < $signed(keys[j-1])) begin
                keys[j] = keys[j-1];
                j--;
            end
            keys[j] = tmp;
        end
        for (int k = 0; k < keys.size(); k++) begin
            r.sorted_key = keys[k];
            r.run_end    = (k == keys.size() - 1);
            r.overflow   = keys_dropped;
            sorted_q.push_back(r);
        end
        held_keys.delete();
        keys_dropped = 0;
    endfunction

    // send one key transaction with burst/gap pacing
    task automatic send_key(input logic [KeyW-1:0] key, input bit fin);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_if.valid     = 1'b1;
        in_if.key       = key;
        in_if.final_key = fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (held_keys.size() < MaxKeys) held_keys.push_back(key);
        else keys_dropped = 1;
        if (fin) begin
            predict_run();
            sets_sent++;
        end
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    function automatic logic [KeyW-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: rand_key = 64'h8000_0000_0000_0000;
            1: rand_key = 64'h7fff_ffff_ffff_ffff;
            2: rand_key = 64'($signed($urandom_range(0, 8)) - 4);
            default: rand_key = {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) send_key(rand_key(), i == n - 1);
    endtask

    task automatic wait_drained();
        while (sorted_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // single keys, extremes, equal keys, sign boundary
    task automatic test_directed();
        send_key(64'h7fff_ffff_ffff_ffff, 1'b1);
        send_key(64'h8000_0000_0000_0000, 1'b1);
        send_key(64'h7fff_ffff_ffff_ffff, 1'b0);
        send_key(64'h0000_0000_0000_0000, 1'b0);
        send_key(64'hffff_ffff_ffff_ffff, 1'b0);
        send_key(64'h8000_0000_0000_0000, 1'b0);
        send_key(64'h0000_0000_0000_0001, 1'b0);
        send_key(64'h5555_5555_5555_5555, 1'b0);
        send_key(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        for (int i = 0; i < 5; i++) send_key(64'd7, i == 4);
        for (int i = 0; i < 6; i++) send_key(64'(i), i == 5);
        for (int i = 0; i < 6; i++) send_key(64'(-i), i == 5);
    endtask

    // store full and overflow, closing key dropped too
    task automatic test_overflow();
        for (int i = 0; i < MaxKeys + 3; i++) send_key(rand_key(), i == MaxKeys + 2);
        for (int i = 0; i < MaxKeys; i++) send_key(rand_key(), i == MaxKeys - 1);
    endtask

    // random sets, mostly small, with a full drain pause in the middle
    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 50) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                             : $urandom_range(1, 8);
            send_set(n);
            sent += n;
            if (sent > 25 && sent - n <= 25) wait_drained();
        end
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 3) != 0);
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_sorted exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
                $error("unexpected result transaction key=%h", out_if.sorted_key);
                fail_count++;
            end else begin
                exp_r = sorted_q.pop_front();
                if (out_if.sorted_key !== exp_r.sorted_key) begin
                    $error("sorted_key expected %h actual %h",
                           exp_r.sorted_key, out_if.sorted_key);
                    fail_count++;
                end
                if (out_if.run_end !== exp_r.run_end) begin
                    $error("run_end expected %b actual %b", exp_r.run_end, out_if.run_end);
                    fail_count++;
                end
                if (out_if.overflow !== exp_r.overflow) begin
                    $error("overflow expected %b actual %b",
                           exp_r.overflow, out_if.overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count   = 0;
        results_seen = 0;
        sets_sent    = 0;
        burst_left   = 0;
        keys_dropped = 0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.key       = '0;
        in_if.final_key = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_overflow();
        test_random();
        wait_drained();
        if (sorted_q.size() != 0) begin
            $error("%0d expected results never arrived", sorted_q.size());
            fail_count++;
        end
        $display("covered %0d key sets, %0d sorted results, overflow and extremes",
                 sets_sent, results_seen);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* ascending_sort_engine.f */
hdl/ase_pkg.sv
hdl/ase_if.sv
hdl/ase_ram.sv
hdl/ascending_sort_engine.sv
tb/sv/tb_top.sv
